// ----- rtl/core/indexed_shift_list_top_macros.svh -----
// ----------------------------------------------------------------------------
// Indexed shift list assertion macros
// Shared concurrent assertion forms for the indexed shift list RTL.
// ----------------------------------------------------------------------------
`ifndef INDEXED_SHIFT_LIST_TOP_MACROS_SVH
`define INDEXED_SHIFT_LIST_TOP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ISL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define ISL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/isl_pkg.sv -----
// ----------------------------------------------------------------------------
// Indexed shift list package
// Field widths, command and status codes, FSM states, control/status bundles.
// ----------------------------------------------------------------------------
package isl_pkg;

  localparam int unsigned CAPACITY_DEF = 64;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_POP_BACK   = 3'd1,
    CMD_PUSH_FRONT = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_INSERT     = 3'd4,
    CMD_REMOVE     = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_INS_SHIFT,
    S_INS_PUT,
    S_REM_TAKE,
    S_REM_SHIFT,
    S_FINISH
  } state_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_LOAD_AT,
    IDX_LOAD_LAST,
    IDX_DEC,
    IDX_INC
  } idx_op_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_AT_DIN,
    WR_UP,
    WR_DOWN
  } wr_op_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;
    idx_op_t idx_op;
    logic    rd_en;
    wr_op_t  wr_op;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    dout_ld;
    logic    status_ld;
    status_t status;
    logic    out_load;
  } isl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    cmd_t cmd;
    logic bad_ins;
    logic bad_rem;
    logic full;
    logic empty;
    logic at_is_end;
    logic idx_at;
    logic idx_last;
    logic out_free;
  } isl_stat_t;

endpackage

// ----- rtl/core/isl_ctrl.sv -----
// ----------------------------------------------------------------------------
// Indexed shift list controller
// Sequences one command at a time: checks, element shifting, result hand-off.
// ----------------------------------------------------------------------------
module isl_ctrl
  import isl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  isl_stat_t stat,
  output isl_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   ins_kind;
  logic   rem_kind;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    ins_kind  = stat.cmd inside {CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_INSERT};
    rem_kind  = stat.cmd inside {CMD_POP_BACK, CMD_POP_FRONT, CMD_REMOVE};
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_FINISH;
        if (ins_kind) begin
          // position check goes before the full check
          if (stat.bad_ins) begin
            cmd.status_ld = 1'b1;
            cmd.status    = ST_BADPOS;
          end else if (stat.full) begin
            cmd.status_ld = 1'b1;
            cmd.status    = ST_FULL;
          end else if (stat.at_is_end) begin
            cmd.wr_op   = WR_AT_DIN;
            cmd.cnt_inc = 1'b1;
          end else begin
            cmd.idx_op = IDX_LOAD_LAST;
            cmd.rd_en  = 1'b1;
            state_nxt  = S_INS_SHIFT;
          end
        end else if (rem_kind) begin
          if (stat.empty) begin
            cmd.status_ld = 1'b1;
            cmd.status    = ST_EMPTY;
          end else if (stat.bad_rem) begin
            cmd.status_ld = 1'b1;
            cmd.status    = ST_BADPOS;
          end else begin
            cmd.idx_op = IDX_LOAD_AT;
            cmd.rd_en  = 1'b1;
            state_nxt  = S_REM_TAKE;
          end
        end
      end
      S_INS_SHIFT: begin
        // move the word read last cycle one slot up
        cmd.wr_op = WR_UP;
        if (stat.idx_at) begin
          state_nxt = S_INS_PUT;
        end else begin
          cmd.idx_op = IDX_DEC;
          cmd.rd_en  = 1'b1;
        end
      end
      S_INS_PUT: begin
        cmd.wr_op   = WR_AT_DIN;
        cmd.cnt_inc = 1'b1;
        state_nxt   = S_FINISH;
      end
      S_REM_TAKE: begin
        cmd.dout_ld = 1'b1;
        if (stat.idx_last) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_FINISH;
        end else begin
          cmd.idx_op = IDX_INC;
          cmd.rd_en  = 1'b1;
          state_nxt  = S_REM_SHIFT;
        end
      end
      S_REM_SHIFT: begin
        // move the word read last cycle one slot down
        cmd.wr_op = WR_DOWN;
        if (stat.idx_last) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_FINISH;
        end else begin
          cmd.idx_op = IDX_INC;
          cmd.rd_en  = 1'b1;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/isl_dp.sv -----
// ----------------------------------------------------------------------------
// Indexed shift list datapath
// Element memory, count, walk index, latched command and result register.
// ----------------------------------------------------------------------------
`include "indexed_shift_list_top_macros.svh"

module isl_dp
  import isl_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [CMD_W-1:0]         in_cmd,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_data_in,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_data_out,
  output logic [STATUS_W-1:0]      out_status,
  output logic [COUNT_W-1:0]       out_count,
  input  isl_cmd_t                 cmd,
  output isl_stat_t                stat
);

  localparam int unsigned ADDR_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned AT_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic signed [DATA_W-1:0] mem [CAPACITY];

  cmd_t                     cmd_r;
  logic [AT_W-1:0]          at_r;
  logic signed [DATA_W-1:0] din_r;
  logic [CNT_W-1:0]         count_r;
  logic [ADDR_W-1:0]        idx_r, idx_nxt;
  logic signed [DATA_W-1:0] rd_data_r;
  logic signed [DATA_W-1:0] dout_r;
  status_t                  status_r;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_data_r;
  status_t                  out_status_r;
  logic [COUNT_W-1:0]       out_count_r;

  logic                     wr_en;
  logic [ADDR_W-1:0]        wr_addr;
  logic signed [DATA_W-1:0] wr_data;
  logic [AT_W-1:0]          at_load;

  // target slot of the incoming command
  always_comb begin
    case (cmd_t'(in_cmd))
      CMD_PUSH_BACK:  at_load = AT_W'(count_r);
      CMD_POP_BACK:   at_load = AT_W'(count_r - CNT_W'(1));
      CMD_PUSH_FRONT: at_load = '0;
      CMD_POP_FRONT:  at_load = '0;
      default:        at_load = AT_W'(in_position);
    endcase
  end

  always_comb begin
    case (cmd.idx_op)
      IDX_LOAD_AT:   idx_nxt = at_r[ADDR_W-1:0];
      IDX_LOAD_LAST: idx_nxt = ADDR_W'(count_r - CNT_W'(1));
      IDX_DEC:       idx_nxt = idx_r - ADDR_W'(1);
      IDX_INC:       idx_nxt = idx_r + ADDR_W'(1);
      default:       idx_nxt = idx_r;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_data = rd_data_r;
    case (cmd.wr_op)
      WR_AT_DIN: begin
        wr_addr = at_r[ADDR_W-1:0];
        wr_data = din_r;
      end
      WR_UP:   wr_addr = idx_r + ADDR_W'(1);
      WR_DOWN: wr_addr = idx_r - ADDR_W'(1);
      default: begin
        wr_en   = 1'b0;
        wr_addr = idx_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[idx_nxt];
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.load) begin
      cmd_r <= cmd_t'(in_cmd);
      at_r  <= at_load;
      din_r <= in_data_in;
    end
    if (cmd.load) begin
      dout_r <= '0;
    end else if (cmd.dout_ld) begin
      dout_r <= rd_data_r;
    end
    if (cmd.load) begin
      status_r <= ST_OK;
    end else if (cmd.status_ld) begin
      status_r <= cmd.status;
    end
    if (cmd.out_load) begin
      out_data_r   <= dout_r;
      out_status_r <= status_r;
      out_count_r  <= COUNT_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        count_r <= count_r + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
        count_r <= count_r - CNT_W'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.cmd       = cmd_r;
    stat.bad_ins   = at_r > AT_W'(count_r);
    stat.bad_rem   = at_r >= AT_W'(count_r);
    stat.full      = count_r == CNT_W'(CAPACITY);
    stat.empty     = count_r == '0;
    stat.at_is_end = at_r == AT_W'(count_r);
    stat.idx_at    = AT_W'(idx_r) == at_r;
    stat.idx_last  = (CNT_W'(idx_r) + CNT_W'(1)) == count_r;
    stat.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid    = out_valid_r;
  assign out_data_out = out_data_r;
  assign out_status   = out_status_r;
  assign out_count    = out_count_r;

  `ISL_ASSERT_IMPL(a_count_in_range, clk, rst_n, 1'b1, count_r <= CNT_W'(CAPACITY),
    "element count above capacity")
  `ISL_ASSERT_IMPL(a_no_grow_when_full, clk, rst_n, cmd.cnt_inc, !stat.full,
    "count raised on a full list")
  `ISL_ASSERT_IMPL(a_no_shrink_when_empty, clk, rst_n, cmd.cnt_dec, !stat.empty,
    "count lowered on an empty list")
  `ISL_ASSERT_IMPL(a_result_slot_free, clk, rst_n, cmd.out_load, stat.out_free,
    "result word overwritten before it was taken")

endmodule

// ----- rtl/core/indexed_shift_list_top.sv -----
// ----------------------------------------------------------------------------
// Indexed shift list
// Fixed-capacity ordered list of signed words with push/pop and indexed edit.
// ----------------------------------------------------------------------------
// One command word in, one result word out. The list lives in a simple
// dual-port memory (one write and one registered read per cycle). An insert
// or push front at position p moves each word from the last one down to p one
// slot up, then writes the new word at p; a remove, pop front or pop back takes
// the word at p as its result and moves each word above p one slot down. A
// command that moves nothing (push back, any rejected command, unused codes)
// goes straight on to the result. The next word is taken once the previous
// result has been loaded into the output register, which may still be waiting
// on out_ready. After reset the list is empty and slot contents are undefined.
module indexed_shift_list_top
  import isl_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [CMD_W-1:0]         in_cmd,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_data_in,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_data_out,
  output logic [STATUS_W-1:0]      out_status,
  output logic [COUNT_W-1:0]       out_count
);

  isl_cmd_t  cmd;
  isl_stat_t stat;

  isl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  isl_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_cmd       (in_cmd),
    .in_position  (in_position),
    .in_data_in   (in_data_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data_out (out_data_out),
    .out_status   (out_status),
    .out_count    (out_count),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule
